@@ rtl/core/acm_pkg.sv @@
// acm_pkg: command and status codes and the result word type of the
// multi-pattern string matcher. No dependencies.
package acm_pkg;

  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_COMPILE = 2'd1;
  localparam logic [1:0] CMD_TEXT    = 2'd2;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  pattern_index;
    logic [31:0] start_position;
    logic [8:0]  node_count;
    logic        last;
  } acm_result_t;

  typedef struct packed {
    logic        valid;
    acm_result_t word;
  } acm_push_t;

endpackage

@@ rtl/core/acm_outbuf.sv @@
// acm_outbuf: one-word output register between the engine and the result port.
// Depends on acm_pkg.
module acm_outbuf
  import acm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  acm_push_t   push_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output acm_result_t word_o
);

  logic        valid_q, valid_d;
  acm_result_t word_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i.valid) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      word_q <= push_i.word;
    end
  end

  assign out_valid_o = valid_q;
  assign word_o      = word_q;

endmodule

@@ rtl/core/acm_engine.sv @@
// acm_engine: sequencer and automaton memories (goto, node info, failure
// link, match mask, pattern length). Depends on acm_pkg.
module acm_engine
  import acm_pkg::*;
#(
  parameter int MAX_NODES     = 256,
  parameter int MAX_PATTERNS  = 16,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] byte_value_i,
  input  logic      end_of_pattern_i,
  output acm_push_t push_o,
  input  logic      slot_free_i
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int SW  = $clog2(ALPHABET_SIZE);
  localparam int DW  = NW + 1;
  localparam int P   = MAX_PATTERNS;
  localparam int PIW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int PCW = $clog2(MAX_PATTERNS + 1);
  localparam int IW  = 2 * NW + SW;
  localparam int GA  = NW + SW;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LD_CHK  = 5'd1;
  localparam logic [4:0] S_LD_G    = 5'd2;
  localparam logic [4:0] S_LD_I    = 5'd3;
  localparam logic [4:0] S_CP_SCAN = 5'd4;
  localparam logic [4:0] S_CP_INFO = 5'd5;
  localparam logic [4:0] S_CP_FR   = 5'd6;
  localparam logic [4:0] S_FL_ST   = 5'd7;
  localparam logic [4:0] S_FL_G    = 5'd8;
  localparam logic [4:0] S_FL_I    = 5'd9;
  localparam logic [4:0] S_FL_F    = 5'd10;
  localparam logic [4:0] S_CP_MT   = 5'd11;
  localparam logic [4:0] S_CP_MS   = 5'd12;
  localparam logic [4:0] S_CP_WR   = 5'd13;
  localparam logic [4:0] S_CP_DONE = 5'd14;
  localparam logic [4:0] S_TX_M    = 5'd15;
  localparam logic [4:0] S_TX_LD   = 5'd16;
  localparam logic [4:0] S_TX_SEL  = 5'd17;
  localparam logic [4:0] S_TX_OUT  = 5'd18;
  localparam logic [4:0] S_CLR     = 5'd19;

  // byte mod ALPHABET_SIZE, constant table
  logic [SW-1:0] sym_tab [256];
  always_comb begin
    for (int i = 0; i < 256; i++) begin
      sym_tab[i] = SW'(i % ALPHABET_SIZE);
    end
  end

  // memories
  logic [NW-1:0] goto_mem [2**GA];
  logic [IW-1:0] info_mem [MAX_NODES];
  logic [NW-1:0] fail_mem [MAX_NODES];
  logic [P-1:0]  mask_mem [MAX_NODES];
  logic [NW-1:0] len_mem  [MAX_PATTERNS];

  logic          goto_re, goto_we;
  logic [GA-1:0] goto_ra, goto_wa;
  logic [NW-1:0] goto_wd, goto_rd_q;
  logic          info_re, info_we;
  logic [NW-1:0] info_ra, info_wa;
  logic [IW-1:0] info_wd, info_rd_q;
  logic          fail_re, fail_we;
  logic [NW-1:0] fail_ra, fail_wa, fail_wd, fail_rd_q;
  logic          mask_re, mask_we;
  logic [NW-1:0] mask_ra, mask_wa;
  logic [P-1:0]  mask_wd, mask_rd_q;
  logic          len_re, len_we;
  logic [PIW-1:0] len_ra, len_wa;
  logic [NW-1:0] len_wd, len_rd_q;

  always_ff @(posedge clk_i) begin
    if (goto_we) goto_mem[goto_wa] <= goto_wd;
    if (goto_re) goto_rd_q <= goto_mem[goto_ra];
  end
  always_ff @(posedge clk_i) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (info_re) info_rd_q <= info_mem[info_ra];
  end
  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    if (fail_re) fail_rd_q <= fail_mem[fail_ra];
  end
  always_ff @(posedge clk_i) begin
    if (mask_we) mask_mem[mask_wa] <= mask_wd;
    if (mask_re) mask_rd_q <= mask_mem[mask_ra];
  end
  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    if (len_re) len_rd_q <= len_mem[len_ra];
  end

  // control state
  logic [4:0]     state_q, state_d;
  logic [NW-1:0]  cur_q, cur_d, ins_q, ins_d, insdep_q, insdep_d, maxdep_q, maxdep_d;
  logic [CW-1:0]  nused_q, nused_d, n_q, n_d;
  logic [PCW-1:0] npat_q, npat_d;
  logic [31:0]    pos_q, pos_d;
  logic           compiled_q, compiled_d, ovf_q, ovf_d, retcp_q, retcp_d;
  logic [DW-1:0]  d_q, d_d;
  logic [GA-1:0]  clr_q, clr_d;
  // working registers
  logic [SW-1:0]  sym_q, sym_d;
  logic           end_q, end_d, lastf_q, lastf_d;
  logic [NW-1:0]  g_q, g_d, fnode_q, fnode_d, res_q, res_d, s_q, s_d;
  logic [P-1:0]   mt_q, mt_d, emask_q, emask_d;
  logic [PIW-1:0] j_q, j_d;

  // node info fields {parent, symbol, depth}
  logic [NW-1:0] i_par, i_dep, chk_node;
  logic [SW-1:0] i_sym;
  logic          hit;
  assign i_dep = info_rd_q[NW-1:0];
  assign i_sym = info_rd_q[NW+SW-1:NW];
  assign i_par = info_rd_q[IW-1:NW+SW];
  assign chk_node = (state_q == S_LD_I) ? ins_q : fnode_q;
  // a goto entry counts only if the node it names was created from this edge
  assign hit = (g_q != '0) && (CW'(g_q) < nused_q) && (i_par == chk_node) && (i_sym == sym_q);

  logic [PIW-1:0] low_idx;
  always_comb begin
    low_idx = '0;
    for (int i = P - 1; i >= 0; i--) begin
      if (emask_q[i]) low_idx = PIW'(i);
    end
  end

  logic [NW-1:0] child;
  logic [P-1:0]  old_mask, pbit;
  logic [4:0]    j5;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;  cur_d = cur_q;  ins_d = ins_q;  insdep_d = insdep_q;
    maxdep_d = maxdep_q;  nused_d = nused_q;  n_d = n_q;  npat_d = npat_q;
    pos_d = pos_q;  compiled_d = compiled_q;  ovf_d = ovf_q;  retcp_d = retcp_q;
    d_d = d_q;  clr_d = clr_q;  sym_d = sym_q;  end_d = end_q;  lastf_d = lastf_q;
    g_d = g_q;  fnode_d = fnode_q;  res_d = res_q;  s_d = s_q;  mt_d = mt_q;
    emask_d = emask_q;  j_d = j_q;
    goto_re = 1'b0; goto_we = 1'b0; goto_ra = '0; goto_wa = '0; goto_wd = '0;
    info_re = 1'b0; info_we = 1'b0; info_ra = '0; info_wa = '0; info_wd = '0;
    fail_re = 1'b0; fail_we = 1'b0; fail_ra = '0; fail_wa = '0; fail_wd = '0;
    mask_re = 1'b0; mask_we = 1'b0; mask_ra = '0; mask_wa = '0; mask_wd = '0;
    len_re = 1'b0;  len_we = 1'b0;  len_ra = '0;  len_wa = '0;  len_wd = '0;
    push_o = '0;
    child = '0;  old_mask = '0;
    pbit = P'(1) << npat_q;
    j5 = 5'(j_q);

    unique case (state_q)
      S_CLR: begin
        // zero the goto memory once after reset
        goto_we = 1'b1; goto_wa = clr_q; goto_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d = sym_tab[byte_value_i];
          end_d = end_of_pattern_i;
          unique case (cmd_i)
            CMD_PATTERN: state_d = S_LD_CHK;
            CMD_COMPILE: begin
              d_d = DW'(2);
              n_d = CW'(1);
              state_d = S_CP_SCAN;
            end
            CMD_TEXT: begin
              if (compiled_q) begin
                fnode_d = cur_q;
                retcp_d = 1'b0;
                state_d = S_FL_ST;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD_CHK: begin
        if (compiled_q) begin
          // fresh dictionary
          cur_d = '0; ins_d = '0; insdep_d = '0; maxdep_d = '0;
          nused_d = CW'(1); npat_d = '0; pos_d = '0;
          compiled_d = 1'b0; ovf_d = 1'b0;
        end else if (ovf_q) begin
          state_d = S_IDLE;
        end else if (npat_q >= PCW'(MAX_PATTERNS)) begin
          ovf_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          goto_re = 1'b1;
          goto_ra = {ins_q, sym_q};
          state_d = S_LD_G;
        end
      end
      S_LD_G: begin
        g_d = goto_rd_q;
        info_re = 1'b1; info_ra = goto_rd_q;
        mask_re = 1'b1; mask_ra = goto_rd_q;
        state_d = S_LD_I;
      end
      S_LD_I: begin
        state_d = S_IDLE;
        if (!hit && nused_q >= CW'(MAX_NODES)) begin
          ovf_d = 1'b1;
        end else begin
          if (hit) begin
            child = g_q;
            old_mask = mask_rd_q;
          end else begin
            child = nused_q[NW-1:0];
            goto_we = 1'b1; goto_wa = {ins_q, sym_q}; goto_wd = child;
            info_we = 1'b1; info_wa = child; info_wd = {ins_q, sym_q, insdep_q + 1'b1};
            fail_we = 1'b1; fail_wa = child; fail_wd = '0;
            nused_d = nused_q + 1'b1;
            if (insdep_q + 1'b1 > maxdep_q) maxdep_d = insdep_q + 1'b1;
          end
          mask_we = !hit || end_q;
          mask_wa = child;
          mask_wd = old_mask | (end_q ? pbit : '0);
          ins_d = child;
          insdep_d = insdep_q + 1'b1;
          if (end_q) begin
            len_we = 1'b1; len_wa = npat_q[PIW-1:0]; len_wd = insdep_q + 1'b1;
            npat_d = npat_q + 1'b1;
            ins_d = '0;
            insdep_d = '0;
          end
        end
      end
      S_CP_SCAN: begin
        if (d_q > DW'(maxdep_q)) begin
          state_d = S_CP_DONE;
        end else if (n_q >= nused_q) begin
          d_d = d_q + 1'b1;
          n_d = CW'(1);
        end else begin
          info_re = 1'b1; info_ra = n_q[NW-1:0];
          state_d = S_CP_INFO;
        end
      end
      S_CP_INFO: begin
        if (i_dep == d_q[NW-1:0]) begin
          s_d = n_q[NW-1:0];
          sym_d = i_sym;
          fail_re = 1'b1; fail_ra = i_par;
          state_d = S_CP_FR;
        end else begin
          n_d = n_q + 1'b1;
          state_d = S_CP_SCAN;
        end
      end
      S_CP_FR: begin
        fnode_d = fail_rd_q;
        retcp_d = 1'b1;
        state_d = S_FL_ST;
      end
      S_FL_ST: begin
        goto_re = 1'b1; goto_ra = {fnode_q, sym_q};
        state_d = S_FL_G;
      end
      S_FL_G: begin
        g_d = goto_rd_q;
        info_re = 1'b1; info_ra = goto_rd_q;
        state_d = S_FL_I;
      end
      S_FL_I: begin
        if (hit || fnode_q == '0) begin
          res_d = hit ? g_q : '0;
          state_d = retcp_q ? S_CP_MT : S_TX_M;
        end else begin
          fail_re = 1'b1; fail_ra = fnode_q;
          state_d = S_FL_F;
        end
      end
      S_FL_F: begin
        fnode_d = fail_rd_q;
        state_d = S_FL_ST;
      end
      S_CP_MT: begin
        mask_re = 1'b1; mask_ra = res_q;
        state_d = S_CP_MS;
      end
      S_CP_MS: begin
        mt_d = (res_q == '0) ? '0 : mask_rd_q;
        mask_re = 1'b1; mask_ra = s_q;
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        mask_we = 1'b1; mask_wa = s_q; mask_wd = mask_rd_q | mt_q;
        fail_we = 1'b1; fail_wa = s_q; fail_wd = res_q;
        n_d = n_q + 1'b1;
        state_d = S_CP_SCAN;
      end
      S_CP_DONE: begin
        if (slot_free_i) begin
          push_o.valid = 1'b1;
          push_o.word.status = ovf_q ? ST_OVF : ST_OK;
          push_o.word.node_count = 9'(nused_q);
          push_o.word.last = 1'b1;
          cur_d = '0; ins_d = '0; insdep_d = '0; pos_d = '0;
          compiled_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TX_M: begin
        cur_d = res_q;
        mask_re = 1'b1; mask_ra = res_q;
        state_d = S_TX_LD;
      end
      S_TX_LD: begin
        emask_d = (res_q == '0) ? '0 : mask_rd_q;
        state_d = S_TX_SEL;
      end
      S_TX_SEL: begin
        if (emask_q == '0) begin
          pos_d = pos_q + 32'd1;
          state_d = S_IDLE;
        end else begin
          j_d = low_idx;
          len_re = 1'b1; len_ra = low_idx;
          emask_d = emask_q & ~(P'(1) << low_idx);
          lastf_d = ((emask_q & ~(P'(1) << low_idx)) == '0);
          state_d = S_TX_OUT;
        end
      end
      S_TX_OUT: begin
        if (slot_free_i) begin
          push_o.valid = 1'b1;
          push_o.word.status = ST_MATCH;
          push_o.word.pattern_index = j5[3:0];
          push_o.word.start_position = pos_q - 32'(len_rd_q) + 32'd1;
          push_o.word.last = lastf_q;
          if (lastf_q) begin
            pos_d = pos_q + 32'd1;
            state_d = S_IDLE;
          end else begin
            state_d = S_TX_SEL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;  cur_q <= '0;  ins_q <= '0;  insdep_q <= '0;
      maxdep_q <= '0;  nused_q <= CW'(1);  n_q <= '0;  npat_q <= '0;
      pos_q <= '0;  compiled_q <= 1'b0;  ovf_q <= 1'b0;  retcp_q <= 1'b0;
      d_q <= '0;  clr_q <= '0;
    end else begin
      state_q <= state_d;  cur_q <= cur_d;  ins_q <= ins_d;  insdep_q <= insdep_d;
      maxdep_q <= maxdep_d;  nused_q <= nused_d;  n_q <= n_d;  npat_q <= npat_d;
      pos_q <= pos_d;  compiled_q <= compiled_d;  ovf_q <= ovf_d;  retcp_q <= retcp_d;
      d_q <= d_d;  clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;  end_q <= end_d;  lastf_q <= lastf_d;  g_q <= g_d;
    fnode_q <= fnode_d;  res_q <= res_d;  s_q <= s_d;  mt_q <= mt_d;
    emask_q <= emask_d;  j_q <= j_d;
  end

endmodule

@@ rtl/core/multi_pattern_string_matcher.sv @@
// Steps: a pattern byte reads its goto entry, then node info and match mask, then writes;
//   a text byte walks goto entries and failure links, then reads the match mask and sends
//   one word per match; text before compile is dropped; compile scans the nodes of each
//   trie depth level in turn and follows failure links for each node below depth one.
// Flow: one item at a time, set by the memory read chain;
//   a word shows on the port in the cycle after it is made; a full output register stalls the engine.
// Reset: control registers cleared, dictionary empty; the goto memory, 2^(log2 nodes
//   + log2 alphabet) entries (65536 by default), is zeroed with input held off.
// Depends on acm_pkg, acm_engine, acm_outbuf.
module multi_pattern_string_matcher
  import acm_pkg::*;
#(
  parameter int MAX_NODES     = 256,
  parameter int MAX_PATTERNS  = 16,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_pattern_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  pattern_index_o,
  output logic [31:0] start_position_o,
  output logic [8:0]  node_count_o,
  output logic        last_o
);

  acm_push_t   push;
  logic        slot_free;
  acm_result_t word;

  // Trie walk, failure-link compile and match reporting all run in the engine;
  // a goto entry is trusted only when the child's stored parent and symbol
  // agree, so entries left from an earlier dictionary are harmless.
  acm_engine #(
    .MAX_NODES    (MAX_NODES),
    .MAX_PATTERNS (MAX_PATTERNS),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .byte_value_i    (byte_value_i),
    .end_of_pattern_i(end_of_pattern_i),
    .push_o          (push),
    .slot_free_i     (slot_free)
  );

  // Output word register: the engine moves on while a word waits.
  acm_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .free_o     (slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .word_o     (word)
  );

  assign status_o         = word.status;
  assign pattern_index_o  = word.pattern_index;
  assign start_position_o = word.start_position;
  assign node_count_o     = word.node_count;
  assign last_o           = word.last;

endmodule

@@ rtl/core/acm_checker.sv @@
// acm_checker: port-level assertions for the matcher, bound to the top level.
// Depends on acm_pkg and multi_pattern_string_matcher.
module acm_checker
  import acm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [3:0]  pattern_index_o,
  input logic [31:0] start_position_o,
  input logic [8:0]  node_count_o,
  input logic        last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(start_position_o)
      && $stable(status_o) && $stable(last_o))
    else $error("output word changed while stalled");

  a_cmp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_MATCH |-> last_o)
    else $error("compile word without last");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_MATCH |-> pattern_index_o == 4'd0
      && start_position_o == 32'd0)
    else $error("compile word with match fields set");

  a_match_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_MATCH |-> node_count_o == 9'd0)
    else $error("match word with node count set");

  a_no_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result one cycle after accept");

endmodule

bind multi_pattern_string_matcher acm_checker u_acm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .pattern_index_o (pattern_index_o),
  .start_position_o(start_position_o),
  .node_count_o    (node_count_o),
  .last_o          (last_o)
);

@@ test/multi_pattern_string_matcher_tb.sv @@
// multi_pattern_string_matcher_tb: self-checking testbench for the Aho-Corasick matcher.
// Builds dictionaries, compiles them and streams text; every output word is checked
// against an in-bench automaton. Depends on acm_pkg and multi_pattern_string_matcher.
module multi_pattern_string_matcher_tb;
  import acm_pkg::*;

  localparam int NODE_LIMIT  = 256;
  localparam int PAT_LIMIT   = 16;
  localparam int SYMS        = 256;
  localparam int DRAIN_GAP   = 40;       // quiet cycles after the last word before a pause ends
  localparam int STALL_LIMIT = 2000000;  // compile of a full trie scans every row
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] sym;
    logic       eop;
    bit         drain;  // hold off until all words are back
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [7:0]  byte_value_i;
  logic        end_of_pattern_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [3:0]  pattern_index_o;
  logic [31:0] start_position_o;
  logic [8:0]  node_count_o;
  logic        last_o;

  multi_pattern_string_matcher u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .byte_value_i, .end_of_pattern_i,
    .out_valid_o, .out_ready_i, .status_o, .pattern_index_o, .start_position_o,
    .node_count_o, .last_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Automaton mirror: trie, failure links, merged match masks
  // ---------------------------------------------------------------------------
  int unsigned ac_goto [NODE_LIMIT*SYMS];
  int unsigned ac_fail [NODE_LIMIT];
  int unsigned ac_mask [NODE_LIMIT];
  int unsigned ac_plen [PAT_LIMIT];
  int unsigned bfs_q   [NODE_LIMIT];
  int unsigned cur_state, ins_state, node_total, pat_total;
  logic [31:0] txt_pos;
  bit          dict_compiled, dict_overflow;

  req_t        pending[$];   // words still to send
  acm_result_t expected[$];  // predicted output words, oldest first
  bit          failed = 1'b0;

  function automatic void dict_clear_node(int unsigned node);
    for (int s = 0; s < SYMS; s++) ac_goto[node*SYMS + s] = 0;
    ac_mask[node] = 0;
    ac_fail[node] = 0;
  endfunction

  function automatic void dict_restart();
    dict_clear_node(0);
    cur_state = 0; ins_state = 0; node_total = 1; pat_total = 0;
    txt_pos = '0; dict_compiled = 0; dict_overflow = 0;
  endfunction

  function automatic void dict_insert(int unsigned sym, bit eop);
    int unsigned child;
    if (dict_compiled) dict_restart();
    if (dict_overflow) return;
    if (pat_total >= PAT_LIMIT) begin
      dict_overflow = 1;
      return;
    end
    if (ins_state == 0) ac_plen[pat_total] = 1;
    else ac_plen[pat_total] += 1;
    child = ac_goto[ins_state*SYMS + sym];
    if (child == 0) begin
      if (node_total >= NODE_LIMIT) begin
        dict_overflow = 1;
        return;
      end
      child = node_total++;
      dict_clear_node(child);
      ac_goto[ins_state*SYMS + sym] = child;
    end
    ins_state = child;
    if (eop) begin
      ac_mask[ins_state] |= 1 << pat_total;
      pat_total++;
      ins_state = 0;
    end
  endfunction

  // goto with failure fallback; root misses go back to root
  function automatic int unsigned ac_next(int unsigned node, int unsigned sym);
    int unsigned guard = 0;
    while (node != 0 && ac_goto[node*SYMS + sym] == 0 && guard < NODE_LIMIT) begin
      node = ac_fail[node];
      guard++;
    end
    if (ac_goto[node*SYMS + sym] == 0 && node != 0) node = 0;
    return ac_goto[node*SYMS + sym];
  endfunction

  function automatic void dict_compile();
    int unsigned head = 0, tail = 0, r, s, t;
    for (int sym = 0; sym < SYMS; sym++) begin
      s = ac_goto[sym];
      if (s != 0 && tail < NODE_LIMIT) begin
        ac_fail[s] = 0;
        bfs_q[tail++] = s;
      end
    end
    while (head < tail) begin
      r = bfs_q[head++];
      for (int sym = 0; sym < SYMS; sym++) begin
        s = ac_goto[r*SYMS + sym];
        if (s != 0) begin
          if (tail < NODE_LIMIT) bfs_q[tail++] = s;
          t = ac_next(ac_fail[r], sym);
          ac_fail[s] = t;
          ac_mask[s] |= ac_mask[t];
        end
      end
    end
    cur_state = 0; ins_state = 0; txt_pos = '0; dict_compiled = 1;
  endfunction

  // append one predicted word
  function automatic void expect_word(acm_result_t w);
    expected.insert(expected.size(), w);
  endfunction

  // advance the mirror by one accepted word and queue the words it causes
  function automatic void predict_word(req_t rq);
    acm_result_t w;
    int          first_idx;
    case (rq.cmd)
      CMD_PATTERN: dict_insert(rq.sym, rq.eop);
      CMD_COMPILE: begin
        dict_compile();
        w = '0;
        w.status     = dict_overflow ? ST_OVF : ST_OK;
        w.node_count = node_total[8:0];
        w.last       = 1'b1;
        expect_word(w);
      end
      CMD_TEXT: if (dict_compiled) begin
        cur_state = ac_next(cur_state, rq.sym);
        first_idx = expected.size();
        for (int j = 0; j < PAT_LIMIT; j++) begin
          if (ac_mask[cur_state][j]) begin
            w = '0;
            w.status         = ST_MATCH;
            w.pattern_index  = j[3:0];
            w.start_position = txt_pos - ac_plen[j] + 1;
            expect_word(w);
          end
        end
        if (expected.size() > first_idx) expected[expected.size()-1].last = 1'b1;
        txt_pos++;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int unsigned n_items = 0;

  task automatic push_req(logic [1:0] c, logic [7:0] b, logic e, bit d = 0);
    req_t rq;
    rq.cmd = c; rq.sym = b; rq.eop = e; rq.drain = d;
    pending.insert(pending.size(), rq);
    n_items++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word in flight, payload held until accepted
  // ---------------------------------------------------------------------------
  req_t        cur_req;
  int unsigned in_gap = 0, drain_cnt = 0;
  bit          in_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    bit fire, nxt_valid;
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      cmd_i            <= CMD_UNUSED;
      byte_value_i     <= '0;
      end_of_pattern_i <= 1'b0;
    end else begin
      fire      = in_valid_i && in_ready_o;
      nxt_valid = in_valid_i && !fire;
      if (fire) begin
        predict_word(cur_req);
        if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0) begin
          if (pending[0].drain && !(expected.size() == 0 && drain_cnt >= DRAIN_GAP)) begin
            drain_cnt = (expected.size() == 0) ? drain_cnt + 1 : 0;
          end else begin
            drain_cnt = 0;
            cur_req   = pending.pop_front();
            nxt_valid = 1'b1;
            in_gap    = in_burst ? 0 : pick_gap();
            cmd_i            <= cur_req.cmd;
            byte_value_i     <= cur_req.sym;
            end_of_pattern_i <= cur_req.eop;
          end
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, in-order compare
  // ---------------------------------------------------------------------------
  int unsigned out_gap = 0;
  bit          out_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    acm_result_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, pattern_index_o, start_position_o, node_count_o, last_o};
        if (expected.size() == 0) begin
          $display("%0t: unexpected word status=%0d idx=%0d start=%0d nodes=%0d last=%0d",
                   $time, got.status, got.pattern_index, got.start_position,
                   got.node_count, got.last);
          failed = 1'b1;
        end else begin
          want = expected.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status=%0d idx=%0d start=%0d nodes=%0d last=%0d",
                     $time, want.status, want.pattern_index, want.start_position,
                     want.node_count, want.last);
            $display("%0t:          actual   status=%0d idx=%0d start=%0d nodes=%0d last=%0d",
                     $time, got.status, got.pattern_index, got.start_position,
                     got.node_count, got.last);
            failed = 1'b1;
          end
        end
        if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!out_burst && $urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  // watchdog: cycles without any accepted word on either side
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] abc[3];
    int unsigned kind, npat, plen;
    dict_restart();

    // text before any compile and the unused command leave no trace
    push_req(CMD_TEXT, 8'h41, 1'b0);
    push_req(CMD_UNUSED, 8'hFF, 1'b1);
    // overlapping patterns at the byte extremes, one left unterminated
    push_req(CMD_PATTERN, 8'h00, 1'b0);
    push_req(CMD_PATTERN, 8'hFF, 1'b1);
    push_req(CMD_PATTERN, 8'hFF, 1'b1);
    push_req(CMD_PATTERN, 8'h80, 1'b0);
    push_req(CMD_PATTERN, 8'h00, 1'b0);
    push_req(CMD_PATTERN, 8'hFF, 1'b1);
    push_req(CMD_PATTERN, 8'h7F, 1'b0);
    push_req(CMD_COMPILE, 8'h00, 1'b0);
    push_req(CMD_TEXT, 8'h80, 1'b0);
    push_req(CMD_TEXT, 8'h00, 1'b1);
    push_req(CMD_TEXT, 8'hFF, 1'b0);
    push_req(CMD_TEXT, 8'hFF, 1'b0);
    push_req(CMD_TEXT, 8'h7F, 1'b0);
    push_req(CMD_UNUSED, 8'h00, 1'b0);
    // repeated compile rebuilds and resets the position
    push_req(CMD_COMPILE, 8'hAA, 1'b1);
    push_req(CMD_TEXT, 8'h00, 1'b0);
    push_req(CMD_TEXT, 8'hFF, 1'b0);

    // node overflow: one full pattern, then a chain that runs out of nodes
    push_req(CMD_PATTERN, 8'h12, 1'b0, 1'b1);
    push_req(CMD_PATTERN, 8'h34, 1'b1);
    for (int i = 0; i < 258; i++) push_req(CMD_PATTERN, 8'($urandom), 1'b0);
    push_req(CMD_COMPILE, 8'h00, 1'b0);
    push_req(CMD_TEXT, 8'h12, 1'b0);
    push_req(CMD_TEXT, 8'h34, 1'b0);

    // random phases: mostly well-formed dictionaries with matching text
    while (n_items < 420) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // pattern overflow: too many short patterns
        npat = $urandom_range(17, 19);
        for (int p = 0; p < npat; p++) push_req(CMD_PATTERN, 8'($urandom), 1'b1);
        push_req(CMD_COMPILE, 8'($urandom), 1'($urandom));
      end else if (kind == 1) begin
        // noise, any command and byte
        repeat ($urandom_range(5, 15))
          push_req(2'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        foreach (abc[i]) abc[i] = 8'($urandom);
        npat = $urandom_range(1, 6);
        for (int p = 0; p < npat; p++) begin
          plen = $urandom_range(1, 4);
          for (int k = 0; k < plen; k++)
            push_req(CMD_PATTERN, abc[$urandom_range(0, 2)], 1'(k == plen - 1));
        end
        if ($urandom_range(0, 3) == 0)
          push_req(CMD_PATTERN, abc[$urandom_range(0, 2)], 1'b0);
        push_req(CMD_COMPILE, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 7) == 0) push_req(CMD_COMPILE, 8'($urandom), 1'b0);
        repeat ($urandom_range(20, 50)) begin
          if ($urandom_range(0, 15) == 0)
            push_req(CMD_TEXT, 8'($urandom), 1'($urandom), $urandom_range(0, 30) == 0);
          else
            push_req(CMD_TEXT, abc[$urandom_range(0, 2)], 1'($urandom));
        end
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || expected.size() != 0);
    repeat (200) @(posedge clk_i);

    if (!failed && expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
